@@ hw/rtl/i2c_mbe_pkg.sv @@
// shared types and constants of the i2c master byte engine
// no dependencies
`timescale 1ns / 1ps

package i2c_mbe_pkg;

    localparam int unsigned HALF_W  = 16;
    localparam int unsigned POLL_W  = 8;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CMD_W   = 3;
    localparam int unsigned BIT_W   = 4;

    localparam logic [HALF_W-1:0] HALF_RESET = 16'd5;
    localparam logic [POLL_W-1:0] POLL_RESET = 8'd250;

    // command codes
    localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START = 3'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    // configuration register indexes
    localparam logic CFG_HALF_PERIOD = 1'b0;
    localparam logic CFG_ACK_TIMEOUT = 1'b1;

    typedef enum logic [13:0] {
        PH_IDLE     = 14'b00000000000001,
        PH_ST_A     = 14'b00000000000010,
        PH_ST_B     = 14'b00000000000100,
        PH_SP_A     = 14'b00000000001000,
        PH_SP_B     = 14'b00000000010000,
        PH_WR_SET   = 14'b00000000100000,
        PH_WR_HIGH  = 14'b00000001000000,
        PH_WR_LOW   = 14'b00000010000000,
        PH_ACK_HIGH = 14'b00000100000000,
        PH_ACK_POLL = 14'b00001000000000,
        PH_RD_LOW   = 14'b00010000000000,
        PH_RD_HIGH  = 14'b00100000000000,
        PH_AK_LOW   = 14'b01000000000000,
        PH_AK_HIGH  = 14'b10000000000000
    } t_phase;

    typedef struct packed {
        logic              scl_level;
        logic              sda_level;
        logic              sda_enable;
        logic              busy_res;
        logic              done_res;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_error;
    } t_result;

endpackage

@@ hw/rtl/i2c_mbe_fsm.sv @@
// bus sequencer of the i2c master byte engine: config registers, phase state, one tick per request
// depends on i2c_mbe_pkg
`timescale 1ns / 1ps

module i2c_mbe_fsm import i2c_mbe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [HALF_W-1:0] i_cfg_data,
    input  logic              i_accept,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [BYTE_W-1:0] i_tx_byte,
    input  logic              i_send_ack,
    input  logic              i_sda_in,
    output t_result           o_result
);

    logic [HALF_W-1:0] r_half,  n_half;
    logic [POLL_W-1:0] r_tmo,   n_tmo;
    t_phase            r_phase, n_phase;
    logic [BIT_W-1:0]  r_bit,   n_bit;
    logic [HALF_W-1:0] r_wait,  n_wait;
    logic [BYTE_W-1:0] r_shift, n_shift;
    logic [POLL_W-1:0] r_poll,  n_poll;
    logic              r_ackc,  n_ackc;
    logic              r_scl,   n_scl;
    logic              r_sda,   n_sda;
    logic              r_en,    n_en;
    logic              r_err,   n_err;
    logic [BYTE_W-1:0] r_rx,    n_rx;
    logic              n_done;
    logic [HALF_W-1:0] w_hp;
    logic [BIT_W-1:0]  w_bit_inc;
    logic [BYTE_W-1:0] w_shl;

    // zero half period behaves as one tick
    assign w_hp      = (r_half == '0) ? {{(HALF_W-1){1'b0}}, 1'b1} : r_half;
    assign w_bit_inc = r_bit + 1'b1;
    assign w_shl     = {r_shift[BYTE_W-2:0], 1'b0};

    always_comb begin
        n_half = r_half;
        n_tmo  = r_tmo;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HALF_PERIOD: n_half = i_cfg_data;
                CFG_ACK_TIMEOUT: n_tmo  = i_cfg_data[POLL_W-1:0];
                default:         n_half = r_half;
            endcase
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_bit   = r_bit;
        n_wait  = r_wait;
        n_shift = r_shift;
        n_poll  = r_poll;
        n_ackc  = r_ackc;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_en    = r_en;
        n_err   = r_err;
        n_rx    = r_rx;
        n_done  = 1'b0;
        if (i_accept) begin
            if (r_phase == PH_IDLE) begin
                // commands only start from idle
                case (i_command)
                    CMD_START: begin
                        n_phase = PH_ST_A;
                        n_scl = 1'b1; n_sda = 1'b1; n_en = 1'b1; n_wait = w_hp;
                    end
                    CMD_STOP: begin
                        n_phase = PH_SP_A;
                        n_scl = 1'b0; n_sda = 1'b0; n_en = 1'b1; n_wait = w_hp;
                    end
                    CMD_WRITE: begin
                        n_shift = i_tx_byte;
                        n_bit   = '0;
                        n_phase = PH_WR_SET;
                        n_scl = 1'b0; n_sda = i_tx_byte[BYTE_W-1]; n_en = 1'b1;
                        n_wait = w_hp;
                    end
                    CMD_READ: begin
                        n_shift = '0;
                        n_bit   = '0;
                        n_ackc  = i_send_ack;
                        n_phase = PH_RD_LOW;
                        n_scl = 1'b0; n_sda = 1'b0; n_en = 1'b0; n_wait = w_hp;
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end else if (r_phase == PH_ACK_POLL ||
                         (r_phase == PH_ACK_HIGH && r_wait <= 16'd1)) begin
                // ack check once scl has been high for a half period
                if (!i_sda_in) begin
                    n_scl   = 1'b0;
                    n_err   = 1'b0;
                    n_phase = PH_IDLE;
                    n_wait  = '0;
                    n_done  = 1'b1;
                end else if (r_poll >= r_tmo) begin
                    n_err   = 1'b1;
                    n_phase = PH_SP_A;
                    n_scl = 1'b0; n_sda = 1'b0; n_en = 1'b1; n_wait = w_hp;
                end else begin
                    n_poll  = r_poll + 1'b1;
                    n_phase = PH_ACK_POLL;
                    n_wait  = '0;
                end
            end else if (r_wait > 16'd1) begin
                n_wait = r_wait - 1'b1;
            end else begin
                case (r_phase)
                    PH_ST_A: begin
                        n_phase = PH_ST_B;
                        n_scl = 1'b1; n_sda = 1'b0; n_en = 1'b1; n_wait = w_hp;
                    end
                    PH_ST_B: begin
                        n_scl = 1'b0; n_phase = PH_IDLE; n_wait = '0; n_done = 1'b1;
                    end
                    PH_SP_A: begin
                        n_phase = PH_SP_B;
                        n_scl = 1'b1; n_sda = 1'b0; n_en = 1'b1; n_wait = w_hp;
                    end
                    PH_SP_B: begin
                        n_scl = 1'b1; n_sda = 1'b1; n_en = 1'b1;
                        n_phase = PH_IDLE; n_wait = '0; n_done = 1'b1;
                    end
                    PH_WR_SET: begin
                        n_phase = PH_WR_HIGH;
                        n_scl = 1'b1; n_en = 1'b1; n_wait = w_hp;
                    end
                    PH_WR_HIGH: begin
                        n_phase = PH_WR_LOW;
                        n_scl = 1'b0; n_en = 1'b1; n_wait = w_hp;
                    end
                    PH_WR_LOW: begin
                        n_bit = w_bit_inc;
                        if (w_bit_inc < 4'd8) begin
                            n_shift = w_shl;
                            n_phase = PH_WR_SET;
                            n_scl = 1'b0; n_sda = w_shl[BYTE_W-1]; n_en = 1'b1;
                            n_wait = w_hp;
                        end else begin
                            // release sda for the ack bit
                            n_poll  = '0;
                            n_phase = PH_ACK_HIGH;
                            n_scl = 1'b1; n_sda = 1'b0; n_en = 1'b0; n_wait = w_hp;
                        end
                    end
                    PH_RD_LOW: begin
                        n_phase = PH_RD_HIGH;
                        n_scl = 1'b1; n_sda = 1'b0; n_en = 1'b0; n_wait = w_hp;
                        n_shift = {r_shift[BYTE_W-2:0], i_sda_in};
                    end
                    PH_RD_HIGH: begin
                        n_bit = w_bit_inc;
                        n_wait = w_hp;
                        if (w_bit_inc < 4'd8) begin
                            n_phase = PH_RD_LOW;
                            n_scl = 1'b0; n_sda = 1'b0; n_en = 1'b0;
                        end else begin
                            n_phase = PH_AK_LOW;
                            n_scl = 1'b0; n_sda = !r_ackc; n_en = 1'b1;
                        end
                    end
                    PH_AK_LOW: begin
                        n_phase = PH_AK_HIGH;
                        n_scl = 1'b1; n_en = 1'b1; n_wait = w_hp;
                    end
                    PH_AK_HIGH: begin
                        n_scl = 1'b0; n_rx = r_shift;
                        n_phase = PH_IDLE; n_wait = '0; n_done = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE; n_wait = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half  <= HALF_RESET;
            r_tmo   <= POLL_RESET;
            r_phase <= PH_IDLE;
            r_bit   <= '0;
            r_wait  <= '0;
            r_shift <= '0;
            r_poll  <= '0;
            r_ackc  <= 1'b0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_en    <= 1'b1;
            r_err   <= 1'b0;
            r_rx    <= '0;
        end else begin
            r_half  <= n_half;
            r_tmo   <= n_tmo;
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_wait  <= n_wait;
            r_shift <= n_shift;
            r_poll  <= n_poll;
            r_ackc  <= n_ackc;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_en    <= n_en;
            r_err   <= n_err;
            r_rx    <= n_rx;
        end
    end

    // result reflects the state after this tick
    always_comb begin
        o_result.scl_level  = n_scl;
        o_result.sda_level  = n_en & n_sda;
        o_result.sda_enable = n_en;
        o_result.busy_res   = (n_phase != PH_IDLE);
        o_result.done_res   = n_done;
        o_result.rx_byte    = n_rx;
        o_result.ack_error  = n_err;
    end

endmodule

@@ hw/rtl/i2c_mbe_out_buf.sv @@
// two-entry result buffer: output register plus skid entry
// depends on i2c_mbe_pkg
`timescale 1ns / 1ps

module i2c_mbe_out_buf import i2c_mbe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_data
);

    logic    r_v0, n_v0;
    logic    r_v1, n_v1;
    t_result r_q0, n_q0;
    t_result r_q1, n_q1;
    logic    w_pop;

    assign w_pop = r_v0 & !i_stall;

    always_comb begin
        n_v0 = r_v0;
        n_v1 = r_v1;
        n_q0 = r_q0;
        n_q1 = r_q1;
        if (w_pop) begin
            // push only happens when the skid entry is empty
            if (r_v1) begin
                n_q0 = r_q1;
                n_v1 = 1'b0;
                if (i_push) begin
                    n_q1 = i_data;
                    n_v1 = 1'b1;
                end
            end else if (i_push) begin
                n_q0 = i_data;
            end else begin
                n_v0 = 1'b0;
            end
        end else if (i_push) begin
            if (!r_v0) begin
                n_q0 = i_data;
                n_v0 = 1'b1;
            end else begin
                n_q1 = i_data;
                n_v1 = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= n_v0;
            r_v1 <= n_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_full  = r_v1;
    assign o_valid = r_v0;
    assign o_data  = r_q0;

endmodule

@@ hw/rtl/i2c_master_byte_engine.sv @@
// i2c master byte engine: one request is one time tick of the bus sequencer
// each accepted request's result is registered in the two-entry result buffer
// throughput: one request per cycle while the buffer is not full, set by the
// single-tick sequencer update; requests are still taken while one result waits
// reset: synchronous active low; idle, scl and sda driven high, registers at defaults
`timescale 1ns / 1ps

module i2c_master_byte_engine import i2c_mbe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [HALF_W-1:0] i_cfg_data,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [CMD_W-1:0]  i_command,
    input  logic [BYTE_W-1:0] i_tx_byte,
    input  logic              i_send_ack,
    input  logic              i_sda_in,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_scl_level,
    output logic              o_sda_level,
    output logic              o_sda_enable,
    output logic              o_busy_res,
    output logic              o_done_res,
    output logic [BYTE_W-1:0] o_rx_byte,
    output logic              o_ack_error
);

    logic    w_full;
    logic    w_accept;
    t_result w_result;
    t_result w_out;

    // stall only when both buffer entries hold results
    assign o_in_stall = w_full;
    assign w_accept   = i_in_valid & !w_full;

    // sequencer: state advances exactly once per accepted request
    i2c_mbe_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_command   (i_command),
        .i_tx_byte   (i_tx_byte),
        .i_send_ack  (i_send_ack),
        .i_sda_in    (i_sda_in),
        .o_result    (w_result)
    );

    // result register with skid entry between the two channels
    i2c_mbe_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_result),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_data  (w_out)
    );

    assign o_scl_level  = w_out.scl_level;
    assign o_sda_level  = w_out.sda_level;
    assign o_sda_enable = w_out.sda_enable;
    assign o_busy_res   = w_out.busy_res;
    assign o_done_res   = w_out.done_res;
    assign o_rx_byte    = w_out.rx_byte;
    assign o_ack_error  = w_out.ack_error;

endmodule

@@ sim/tb_i2c_master_byte_engine.sv @@
// self-checking testbench for the i2c master byte engine: pin-level tick predictor,
// randomized valid/stall handshakes on both channels and register sweeps
// depends on i2c_mbe_pkg and i2c_master_byte_engine
`timescale 1ns / 1ps

module tb_i2c_master_byte_engine;
    import i2c_mbe_pkg::*;

    localparam int CYCLE_LIMIT      = 3_000_000;
    localparam int LONG_HOLD_AT     = 300;  // result count that triggers the long output stall
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int END_SETTLE       = 20;

    // sda source for the ticks that follow a command
    localparam int SDA_LOW  = 0;
    localparam int SDA_HIGH = 1;
    localparam int SDA_RUNS = 2;

    // one request: a single time tick of the bus sequencer
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] tx;
        logic              ack;
        logic              sda;
    } tick_req_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // configuration port
    logic              cfg_we    = 1'b0;
    logic              cfg_index = CFG_HALF_PERIOD;
    logic [HALF_W-1:0] cfg_data  = '0;

    // request channel
    logic              req_valid = 1'b0;
    logic              req_stall;
    logic [CMD_W-1:0]  command   = CMD_NONE;
    logic [BYTE_W-1:0] tx_byte   = '0;
    logic              send_ack  = 1'b0;
    logic              sda_in    = 1'b1;

    // result channel
    logic              res_valid;
    logic              res_stall = 1'b0;
    logic              scl_level;
    logic              sda_level;
    logic              sda_enable;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
    logic              ack_error;

    i2c_master_byte_engine i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (req_valid),
        .o_in_stall   (req_stall),
        .i_command    (command),
        .i_tx_byte    (tx_byte),
        .i_send_ack   (send_ack),
        .i_sda_in     (sda_in),
        .o_out_valid  (res_valid),
        .i_out_stall  (res_stall),
        .o_scl_level  (scl_level),
        .o_sda_level  (sda_level),
        .o_sda_enable (sda_enable),
        .o_busy_res   (busy_res),
        .o_done_res   (done_res),
        .o_rx_byte    (rx_byte),
        .o_ack_error  (ack_error)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // bus sequencer predictor: mirrors the engine one tick at a time
    // ------------------------------------------------------------------
    logic [HALF_W-1:0] half_ticks = HALF_RESET;
    logic [POLL_W-1:0] poll_limit = POLL_RESET;

    t_phase            bus_phase   = PH_IDLE;
    logic [BIT_W-1:0]  bit_count   = '0;
    logic [HALF_W-1:0] hold_count  = '0;
    logic [BYTE_W-1:0] shift_reg   = '0;
    logic [POLL_W-1:0] poll_count  = '0;
    logic              ack_wanted  = 1'b0;
    logic              scl_drv     = 1'b1;
    logic              sda_drv     = 1'b1;
    logic              sda_oe      = 1'b1;
    logic              nack_seen   = 1'b0;
    logic [BYTE_W-1:0] last_rx     = '0;
    logic              seq_done    = 1'b0;

    // every step holds its line levels for one half period, zero counts as one
    function automatic void enter_step(t_phase p, logic scl, logic sda, logic oe);
        bus_phase  = p;
        scl_drv    = scl;
        sda_drv    = sda;
        sda_oe     = oe;
        hold_count = (half_ticks != '0) ? half_ticks : HALF_W'(1);
    endfunction

    function automatic void end_sequence();
        bus_phase  = PH_IDLE;
        hold_count = '0;
        seq_done   = 1'b1;
    endfunction

    // low sda is the ack; otherwise count polls until the limit, then stop with error
    function automatic void sample_ack(logic sda);
        if (!sda) begin
            scl_drv   = 1'b0;
            nack_seen = 1'b0;
            end_sequence();
        end else if (poll_count >= poll_limit) begin
            nack_seen = 1'b1;
            enter_step(PH_SP_A, 1'b0, 1'b0, 1'b1);
        end else begin
            poll_count++;
        end
    endfunction

    // next step once the current half period has run out
    function automatic void next_step(logic sda);
        case (bus_phase)
            PH_ST_A: enter_step(PH_ST_B, 1'b1, 1'b0, 1'b1);
            PH_ST_B: begin
                scl_drv = 1'b0;
                end_sequence();
            end
            PH_SP_A: enter_step(PH_SP_B, 1'b1, 1'b0, 1'b1);
            PH_SP_B: begin
                scl_drv = 1'b1;
                sda_drv = 1'b1;
                sda_oe  = 1'b1;
                end_sequence();
            end
            PH_WR_SET:  enter_step(PH_WR_HIGH, 1'b1, sda_drv, 1'b1);
            PH_WR_HIGH: enter_step(PH_WR_LOW, 1'b0, sda_drv, 1'b1);
            PH_WR_LOW: begin
                bit_count = bit_count + 1'b1;
                if (bit_count < 8) begin
                    shift_reg = shift_reg << 1;
                    enter_step(PH_WR_SET, 1'b0, shift_reg[7], 1'b1);
                end else begin
                    // release sda and raise scl for the ack bit
                    poll_count = '0;
                    enter_step(PH_ACK_HIGH, 1'b1, 1'b0, 1'b0);
                end
            end
            PH_ACK_HIGH: begin
                bus_phase  = PH_ACK_POLL;
                hold_count = '0;
                sample_ack(sda);
            end
            PH_RD_LOW: begin
                // data bit is taken as scl rises
                enter_step(PH_RD_HIGH, 1'b1, 1'b0, 1'b0);
                shift_reg = {shift_reg[BYTE_W-2:0], sda};
            end
            PH_RD_HIGH: begin
                bit_count = bit_count + 1'b1;
                if (bit_count < 8) enter_step(PH_RD_LOW, 1'b0, 1'b0, 1'b0);
                else               enter_step(PH_AK_LOW, 1'b0, !ack_wanted, 1'b1);
            end
            PH_AK_LOW: enter_step(PH_AK_HIGH, 1'b1, sda_drv, 1'b1);
            PH_AK_HIGH: begin
                scl_drv = 1'b0;
                last_rx = shift_reg;
                end_sequence();
            end
            default: begin
                bus_phase  = PH_IDLE;
                hold_count = '0;
            end
        endcase
    endfunction

    // one accepted request in, the expected pin levels after that tick out
    function automatic t_result bus_tick(tick_req_t r);
        t_result pins;
        seq_done = 1'b0;
        if (bus_phase == PH_IDLE) begin
            case (r.cmd)
                CMD_START: enter_step(PH_ST_A, 1'b1, 1'b1, 1'b1);
                CMD_STOP:  enter_step(PH_SP_A, 1'b0, 1'b0, 1'b1);
                CMD_WRITE: begin
                    shift_reg = r.tx;
                    bit_count = '0;
                    enter_step(PH_WR_SET, 1'b0, r.tx[7], 1'b1);
                end
                CMD_READ: begin
                    shift_reg  = '0;
                    bit_count  = '0;
                    ack_wanted = r.ack;
                    enter_step(PH_RD_LOW, 1'b0, 1'b0, 1'b0);
                end
                default: ;  // none and unknown codes leave the bus alone
            endcase
        end else if (bus_phase == PH_ACK_POLL) begin
            sample_ack(r.sda);
        end else if (hold_count > 1) begin
            hold_count--;
        end else begin
            next_step(r.sda);
        end
        pins.scl_level  = scl_drv;
        pins.sda_level  = sda_oe ? sda_drv : 1'b0;
        pins.sda_enable = sda_oe;
        pins.busy_res   = (bus_phase != PH_IDLE);
        pins.done_res   = seq_done;
        pins.rx_byte    = last_rx;
        pins.ack_error  = nack_seen;
        return pins;
    endfunction

    // ------------------------------------------------------------------
    // request driver
    // ------------------------------------------------------------------
    tick_req_t pending_ticks[$];
    t_result   expected_pins[$];
    tick_req_t cur_req;
    int        req_gap_left = 0;
    int        max_req_gap  = 3;
    int        max_res_wait = 3;

    always @(posedge clk) begin : req_driver
        logic valid_next;
        if (!rst_n) begin
            req_valid    <= 1'b0;
            req_gap_left = 0;
        end else begin
            valid_next = req_valid;
            // request taken: predict its tick and draw the gap before the next one
            if (req_valid && !req_stall) begin
                expected_pins.push_back(bus_tick(cur_req));
                valid_next   = 1'b0;
                req_gap_left = $urandom_range(0, max_req_gap);
            end
            if (!valid_next) begin
                if (req_gap_left > 0) begin
                    req_gap_left--;
                end else if (pending_ticks.size() != 0) begin
                    cur_req  = pending_ticks.pop_front();
                    command  <= cur_req.cmd;
                    tx_byte  <= cur_req.tx;
                    send_ack <= cur_req.ack;
                    sda_in   <= cur_req.sda;
                    valid_next = 1'b1;
                end
            end
            // single assignment so a back-to-back request keeps valid high
            req_valid <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // result monitor with its own stall pattern
    // ------------------------------------------------------------------
    int fail_count   = 0;
    int result_count = 0;
    int res_hold     = 0;

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin : res_monitor
        t_result want;
        if (!rst_n) begin
            res_stall <= 1'b0;
            res_hold  = 0;
        end else begin
            if (res_valid && !res_stall) begin
                if (expected_pins.size() == 0) begin
                    $error("result with no request outstanding");
                    fail_count++;
                end else begin
                    want = expected_pins.pop_front();
                    check_field("scl_level", want.scl_level, scl_level);
                    check_field("sda_level", want.sda_level, sda_level);
                    check_field("sda_enable", want.sda_enable, sda_enable);
                    check_field("busy_res", want.busy_res, busy_res);
                    check_field("done_res", want.done_res, done_res);
                    check_field("rx_byte", want.rx_byte, rx_byte);
                    check_field("ack_error", want.ack_error, ack_error);
                end
                result_count++;
                res_hold = $urandom_range(0, max_res_wait);
                // one long back-pressure stretch so the engine fills up and stalls requests
                if (result_count == LONG_HOLD_AT) res_hold = LONG_HOLD_CYCLES;
            end
            if (res_hold > 0) begin
                res_hold--;
                res_stall <= 1'b1;
            end else begin
                res_stall <= 1'b0;
            end
        end
    end

    // watchdog
    int cycle_count = 0;

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    int sda_run_left = 0;
    int sda_run_kind = SDA_LOW;
    int items_pushed = 0;

    // sda in runs: stuck low (quick ack), stuck high (timeouts, 0xff reads) or noise
    function automatic logic pick_sda(int mode);
        if (mode == SDA_LOW)  return 1'b0;
        if (mode == SDA_HIGH) return 1'b1;
        if (sda_run_left == 0) begin
            sda_run_kind = $urandom_range(0, 2);
            sda_run_left = $urandom_range(1, 300);
        end
        sda_run_left--;
        if (sda_run_kind == SDA_RUNS) return 1'($urandom);
        return (sda_run_kind == SDA_HIGH);
    endfunction

    function automatic void push_item(logic [CMD_W-1:0] cmd, logic [BYTE_W-1:0] tx,
                                      logic ack, logic sda);
        tick_req_t r;
        r.cmd = cmd;
        r.tx  = tx;
        r.ack = ack;
        r.sda = sda;
        pending_ticks.push_back(r);
        items_pushed++;
    endfunction

    // sender pause: nothing queued, nothing in flight, every result seen
    task automatic wait_drained();
        do @(negedge clk);
        while (pending_ticks.size() != 0 || req_valid || expected_pins.size() != 0);
    endtask

    // feed idle ticks until the predicted sequencer is back to idle
    task automatic settle_bus(input int sda_mode);
        int chunk;
        wait_drained();
        while (bus_phase != PH_IDLE) begin
            chunk = int'(half_ticks) / 4 + 16;
            repeat (chunk) push_item(CMD_NONE, 8'($urandom), 1'($urandom), pick_sda(sda_mode));
            wait_drained();
        end
    endtask

    task automatic do_cmd(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] tx,
                          input logic ack, input int sda_mode);
        push_item(cmd, tx, ack, pick_sda(sda_mode));
        settle_bus(sda_mode);
    endtask

    task automatic write_reg(input logic idx, input logic [HALF_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == CFG_HALF_PERIOD) half_ticks = value;
        else                        poll_limit = value[POLL_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // new register setting, only with the engine drained and the bus idle
    task automatic apply_setting(input logic [HALF_W-1:0] half, input logic [POLL_W-1:0] polls,
                                 input int req_gap, input int res_wait);
        settle_bus(SDA_RUNS);
        repeat (4) @(posedge clk);
        write_reg(CFG_HALF_PERIOD, half);
        write_reg(CFG_ACK_TIMEOUT, HALF_W'(polls));
        max_req_gap  = req_gap;
        max_res_wait = res_wait;
    endtask

    // mostly start / write / write-or-read / read / stop transactions with random
    // content; some commands land while busy or are unknown codes
    task automatic random_traffic(input int count);
        int               start_at;
        int               slot;
        int               tail;
        logic [CMD_W-1:0] cmd;
        start_at = items_pushed;
        slot     = 0;
        while (items_pushed - start_at < count) begin
            if ($urandom_range(0, 9) == 0) begin
                cmd = 3'($urandom_range(0, 7));
            end else begin
                case (slot)
                    0:       cmd = CMD_START;
                    1:       cmd = CMD_WRITE;
                    2:       cmd = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
                    3:       cmd = CMD_READ;
                    default: cmd = CMD_STOP;
                endcase
                slot = (slot + 1) % 5;
            end
            push_item(cmd, 8'($urandom), 1'($urandom), pick_sda(SDA_RUNS));
            tail = $urandom_range(0, 6);
            repeat (tail) begin
                cmd = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : CMD_NONE;
                push_item(cmd, 8'($urandom), 1'($urandom), pick_sda(SDA_RUNS));
            end
            if ($urandom_range(0, 3) != 0) begin
                settle_bus(SDA_RUNS);
            end
        end
    endtask

    initial begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: idle and unknown codes, then each command
        push_item(CMD_NONE, 8'h00, 1'b0, 1'b1);
        push_item(3'd5, 8'hFF, 1'b1, 1'b0);
        push_item(3'd6, 8'h00, 1'b0, 1'b1);
        push_item(3'd7, 8'hFF, 1'b1, 1'b0);
        settle_bus(SDA_RUNS);
        do_cmd(CMD_START, 8'h00, 1'b0, SDA_RUNS);
        do_cmd(CMD_WRITE, 8'hA5, 1'b0, SDA_LOW);
        do_cmd(CMD_WRITE, 8'hFF, 1'b1, SDA_LOW);
        do_cmd(CMD_WRITE, 8'h00, 1'b0, SDA_HIGH);   // no ack: full poll budget then stop
        do_cmd(CMD_READ, 8'h00, 1'b1, SDA_HIGH);
        do_cmd(CMD_READ, 8'hFF, 1'b0, SDA_LOW);
        do_cmd(CMD_READ, 8'h3C, 1'b1, SDA_RUNS);
        do_cmd(CMD_WRITE, 8'h5A, 1'b0, SDA_LOW);    // ack clears the error flag
        do_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RUNS);

        // commands arriving while a start is in progress are dropped
        push_item(CMD_START, 8'h00, 1'b0, 1'b0);
        push_item(CMD_WRITE, 8'h81, 1'b0, 1'b0);
        push_item(CMD_READ, 8'h7E, 1'b1, 1'b1);
        push_item(CMD_STOP, 8'h00, 1'b0, 1'b0);
        settle_bus(SDA_LOW);

        // zero half period and zero poll budget
        apply_setting(16'd0, 8'd0, 3, 3);
        do_cmd(CMD_WRITE, 8'h81, 1'b0, SDA_HIGH);
        do_cmd(CMD_START, 8'h00, 1'b0, SDA_RUNS);
        do_cmd(CMD_READ, 8'h00, 1'b1, SDA_RUNS);
        do_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RUNS);

        // smallest legal settings
        apply_setting(16'd1, 8'd1, 3, 3);
        do_cmd(CMD_WRITE, 8'h5A, 1'b1, SDA_HIGH);
        do_cmd(CMD_READ, 8'hC3, 1'b0, SDA_RUNS);

        // long half period and the largest poll budget
        apply_setting(16'd64, 8'd255, 3, 3);
        do_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RUNS);

        // random transactions over several settings
        apply_setting(16'd1, 8'd3, 3, 3);
        random_traffic(70);
        apply_setting(16'd2, 8'd1, 3, 3);
        random_traffic(60);
        apply_setting(16'd0, 8'd0, 3, 3);
        random_traffic(60);
        apply_setting(16'd1, 8'd255, 3, 3);
        random_traffic(60);
        apply_setting(16'd3, 8'd12, 3, 3);
        random_traffic(50);

        wait_drained();
        repeat (END_SETTLE) @(posedge clk);
        if (expected_pins.size() != 0) begin
            $error("%0d results never arrived", expected_pins.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ i2c_master_byte_engine.f @@
hw/rtl/i2c_mbe_pkg.sv
hw/rtl/i2c_mbe_fsm.sv
hw/rtl/i2c_mbe_out_buf.sv
hw/rtl/i2c_master_byte_engine.sv
sim/tb_i2c_master_byte_engine.sv
